[sv/frustum_cull_test_defines.svh]
// Assertion macros for the frustum culling block.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum_cull_test: check failed");

// Next-cycle implication, disabled during reset.
`define FCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum_cull_test: check failed");

`endif

[sv/fct_pkg.sv]
// Shared types and constants for the frustum culling block.
// Used by fct_cell and frustum_cull_test; no dependencies.
package fct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int PLANE_W    = 64;
  localparam int PROD_W     = 37;
  localparam int DIST_W     = 40;

  typedef enum logic [1:0] {
    MODE_POINT  = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_BOX    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [24:0] d;
    logic signed [12:0] nz;
    logic signed [12:0] ny;
    logic signed [12:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec_t;

  typedef struct packed {
    mode_t              mode;
    vec_t               lo;
    vec_t               hi;
    logic [COORD_W-1:0] radius;
    logic               in_view;
  } item_t;

endpackage

[sv/fct_cell.sv]
// One plane cell of the culling chain: multiply stage, then sum and compare stage.
// Depends on fct_pkg; instantiated six times by frustum_cull_test.
module fct_cell
  import fct_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  plane_t plane,
  input  logic   up_valid,
  output logic   up_ready,
  input  item_t  up_item,
  output logic   dn_valid,
  input  logic   dn_ready,
  output item_t  dn_item
);

  logic                     a_valid_r, a_valid_nxt, a_ready;
  item_t                    a_item_r;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic                     b_valid_r, b_valid_nxt, b_ready;
  item_t                    b_item_r, b_item_nxt;
  logic signed [COORD_W-1:0] sx, sy, sz;
  logic signed [DIST_W-1:0] dist_sum, thr;

  // For a box the nearest corner on each axis follows the sign of the normal.
  always_comb begin
    sx = plane.nx[12] ? up_item.hi.x : up_item.lo.x;
    sy = plane.ny[12] ? up_item.hi.y : up_item.lo.y;
    sz = plane.nz[12] ? up_item.hi.z : up_item.lo.z;
    px_nxt = PROD_W'(plane.nx) * PROD_W'(sx);
    py_nxt = PROD_W'(plane.ny) * PROD_W'(sy);
    pz_nxt = PROD_W'(plane.nz) * PROD_W'(sz);
  end

  assign a_ready     = !a_valid_r || b_ready;
  assign up_ready    = a_ready;
  assign a_valid_nxt = a_ready ? up_valid : a_valid_r;

  always_comb begin
    dist_sum = DIST_W'(px_r) + DIST_W'(py_r) + DIST_W'(pz_r) +
               DIST_W'($signed({plane.d, 11'b0}));
    if (a_item_r.mode == MODE_SPHERE) begin
      thr = $signed({5'b0, a_item_r.radius, 11'b0});
    end else begin
      thr = '0;
    end
    b_item_nxt         = a_item_r;
    b_item_nxt.in_view = a_item_r.in_view && (dist_sum < thr);
  end

  assign b_ready     = !b_valid_r || dn_ready;
  assign b_valid_nxt = b_ready ? a_valid_r : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_item_r <= up_item;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      pz_r     <= pz_nxt;
    end
    if (a_valid_r && b_ready) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_item  = b_item_r;

endmodule

[sv/frustum_cull_test.sv]
// Top level of the six-plane frustum culling block: entry stage and cell chain.
// Depends on fct_pkg, fct_cell and frustum_cull_test_defines.svh.
// Takes one request per clock while the chain is not stalled and returns one inside
// bit per request, in order: one entry register that sorts box corners, then six
// plane cells of two stages each (multiply, then sum and compare). Each stage holds
// its own valid bit, so new requests keep entering while a finished result waits,
// until the chain is full. Planes reset to zero and are written through cfg.
`include "frustum_cull_test_defines.svh"

module frustum_cull_test
  import fct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [PLANE_W-1:0]   cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [167:0]         in_tdata,  // ax, ay, az, bx, by, bz, radius
  input  logic [1:0]           in_tuser,  // mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata  // inside_res, zero fill
);

  logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_r;
  logic                  e_valid_r, e_valid_nxt;
  item_t                 e_item_r, e_item_nxt;
  logic [NUM_PLANES:0]   nv, nr;
  item_t                 ni [NUM_PLANES+1];
  vec_t                  a, b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (cfg_wr_en && cfg_addr == CFG_IDX_W'(i)) begin
          plane_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    a.x = in_tdata[23:0];
    a.y = in_tdata[47:24];
    a.z = in_tdata[71:48];
    b.x = in_tdata[95:72];
    b.y = in_tdata[119:96];
    b.z = in_tdata[143:120];
    e_item_nxt.mode    = mode_t'(in_tuser);
    e_item_nxt.radius  = in_tdata[167:144];
    e_item_nxt.in_view = 1'b1;
    e_item_nxt.lo      = a;
    e_item_nxt.hi      = a;
    case (mode_t'(in_tuser))
      MODE_BOX: begin
        e_item_nxt.lo.x = (a.x < b.x) ? a.x : b.x;
        e_item_nxt.hi.x = (a.x < b.x) ? b.x : a.x;
        e_item_nxt.lo.y = (a.y < b.y) ? a.y : b.y;
        e_item_nxt.hi.y = (a.y < b.y) ? b.y : a.y;
        e_item_nxt.lo.z = (a.z < b.z) ? a.z : b.z;
        e_item_nxt.hi.z = (a.z < b.z) ? b.z : a.z;
      end
      MODE_NONE: begin
        e_item_nxt.in_view = 1'b0;
      end
      default: begin
        e_item_nxt.lo = a;
      end
    endcase
  end

  assign in_tready   = !e_valid_r || nr[0];
  assign e_valid_nxt = in_tready ? in_tvalid : e_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= e_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      e_item_r <= e_item_nxt;
    end
  end

  assign nv[0] = e_valid_r;
  assign ni[0] = e_item_r;

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    fct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (plane_t'(plane_r[g])),
      .up_valid (nv[g]),
      .up_ready (nr[g]),
      .up_item  (ni[g]),
      .dn_valid (nv[g+1]),
      .dn_ready (nr[g+1]),
      .dn_item  (ni[g+1])
    );
  end

  assign nr[NUM_PLANES] = out_tready;
  assign out_tvalid     = nv[NUM_PLANES];
  assign out_tdata      = {7'b0, ni[NUM_PLANES].in_view};

  `FCT_ASSERT_NOW(a_stall_needs_entry, !in_tready, e_valid_r)
  `FCT_ASSERT_NEXT(a_bad_index_ignored, cfg_wr_en && cfg_addr >= CFG_IDX_W'(NUM_PLANES),
                   plane_r == $past(plane_r))
  `FCT_ASSERT_NOW(a_empty_after_reset, !$past(rst_n), !out_tvalid)

endmodule

[dv/frustum_cull_test_checker.sv]
// Checker for the six-plane frustum culling block: mirrors the plane registers,
// predicts the inside bit of every accepted request and compares it in order.
// Depends on fct_pkg only; counts failures and waiting predictions for the top.
module frustum_cull_test_checker
  import fct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [PLANE_W-1:0]   cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [167:0]         in_tdata,  // ax, ay, az, bx, by, bz, radius
  input  logic [1:0]           in_tuser,  // mode
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata, // inside_res, zero fill
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  plane_t planes_q [NUM_PLANES];
  logic   expected_inside [$];

  // Exact signed distance with 11 fraction bits.
  function automatic longint plane_distance(plane_t p, vec_t v);
    longint nx, ny, nz, d, x, y, z;
    nx = p.nx;
    ny = p.ny;
    nz = p.nz;
    d  = p.d;
    x  = v.x;
    y  = v.y;
    z  = v.z;
    return nx * x + ny * y + nz * z + d * 2048;
  endfunction

  function automatic logic frustum_inside(mode_t mode, vec_t lo, vec_t hi,
                                          logic [COORD_W-1:0] radius);
    longint r;
    logic   in_view;
    logic   all_out;
    vec_t   corner;
    int     i;
    int     k;
    r = radius;
    r = r * 2048;
    if (mode == MODE_NONE) return 1'b0;
    in_view = 1'b1;
    for (i = 0; i < NUM_PLANES; i++) begin
      case (mode)
        MODE_POINT: begin
          if (plane_distance(planes_q[i], lo) >= 0) in_view = 1'b0;
        end
        MODE_SPHERE: begin
          if (plane_distance(planes_q[i], lo) >= r) in_view = 1'b0;
        end
        default: begin
          all_out = 1'b1;
          for (k = 0; k < 8; k++) begin
            corner.x = k[0] ? hi.x : lo.x;
            corner.y = k[1] ? hi.y : lo.y;
            corner.z = k[2] ? hi.z : lo.z;
            if (plane_distance(planes_q[i], corner) < 0) all_out = 1'b0;
          end
          if (all_out) in_view = 1'b0;
        end
      endcase
    end
    return in_view;
  endfunction

  always @(posedge clk) begin
    logic want;
    int   i;
    if (!rst_n) begin
      for (i = 0; i < NUM_PLANES; i++) planes_q[i] = '0;
      expected_inside.delete();
    end else begin
      if (cfg_wr_en && cfg_addr < NUM_PLANES) planes_q[cfg_addr] = plane_t'(cfg_wdata);
      // Results always trail their requests, so pop before push.
      if (out_tvalid && out_tready) begin
        if (expected_inside.size() == 0) begin
          fail_count++;
          $display("%0t: result without request, expected none, actual inside_res %0d",
                   $time, out_tdata[0]);
        end else begin
          want = expected_inside.pop_front();
          if (out_tdata[0] !== want) begin
            fail_count++;
            $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata[0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_inside.push_back(frustum_inside(mode_t'(in_tuser), in_tdata[71:0],
                                                 in_tdata[143:72], in_tdata[167:144]));
      end
    end
    pending = expected_inside.size();
  end

endmodule

[dv/frustum_cull_test_tb.sv]
// Top of the frustum culling testbench: clock, reset, plane settings and requests.
// Depends on fct_pkg, frustum_cull_test and frustum_cull_test_checker.
module frustum_cull_test_tb;
  import fct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W           = 256000;
  localparam int COORD_MAX   = 8388607;
  localparam int COORD_MIN   = -8388608;
  localparam int CALM_FROM   = 500;
  localparam int CALM_TO     = 700;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [PLANE_W-1:0]   cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [167:0]         in_tdata;  // ax, ay, az, bx, by, bz, radius
  logic [1:0]           in_tuser;  // mode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata; // inside_res, zero fill
  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  int                   in_accepted = 0;
  logic [PLANE_W-1:0]   plane_set [NUM_PLANES];

  always #5 clk = ~clk;

  frustum_cull_test dut (.*);

  frustum_cull_test_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_tvalid && in_tready) in_accepted++;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic vec_t vec3(int x, int y, int z);
    vec_t v;
    v.x = x[COORD_W-1:0];
    v.y = y[COORD_W-1:0];
    v.z = z[COORD_W-1:0];
    return v;
  endfunction

  function automatic logic [PLANE_W-1:0] make_plane(int nx, int ny, int nz, int d);
    plane_t p;
    p.nx = nx[12:0];
    p.ny = ny[12:0];
    p.nz = nz[12:0];
    p.d  = d[24:0];
    return p;
  endfunction

  // Zero span gives the full signed 24-bit range.
  function automatic int rand_coord(int span);
    logic [31:0] u;
    if (span == 0) begin
      u = $urandom();
      return {{8{u[23]}}, u[23:0]};
    end
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_item(mode_t mode, vec_t lo, vec_t hi, logic [COORD_W-1:0] radius);
    while (!(in_accepted >= CALM_FROM && in_accepted < CALM_TO) &&
           $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {radius, hi, lo};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random(int span);
    int                 pick;
    mode_t              mode;
    vec_t               lo;
    vec_t               hi;
    logic [COORD_W-1:0] radius;
    pick = $urandom_range(15);
    if (pick < 5) mode = MODE_POINT;
    else if (pick < 10) mode = MODE_SPHERE;
    else if (pick < 15) mode = MODE_BOX;
    else mode = MODE_NONE;
    if (span == 0 || $urandom_range(2) == 0) begin
      lo = vec3(rand_coord(0), rand_coord(0), rand_coord(0));
      hi = vec3(rand_coord(0), rand_coord(0), rand_coord(0));
    end else begin
      lo = vec3(rand_coord(span), rand_coord(span), rand_coord(span));
      hi = vec3(lo.x + rand_coord(span / 4), lo.y + rand_coord(span / 4),
                lo.z + rand_coord(span / 4));
    end
    if (span == 0 || $urandom_range(1) == 0) radius = COORD_W'(rand_coord(0));
    else radius = COORD_W'($urandom_range(span / 2));
    send_item(mode, lo, hi, radius);
  endtask

  // Indexes past the last plane get junk, which the block must ignore.
  task automatic load_planes();
    int i;
    for (i = 0; i < NUM_PLANES + 2; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= i[CFG_IDX_W-1:0];
      cfg_wdata <= (i < NUM_PLANES) ? plane_set[i] : {$urandom(), $urandom()};
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && in_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (in_accepted >= CALM_FROM && in_accepted < CALM_TO) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin
    int i;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_POINT;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With every plane at zero, only a sphere of nonzero radius is inside.
    send_item(MODE_POINT, vec3(0, 0, 0), vec3(0, 0, 0), 0);
    send_item(MODE_SPHERE, vec3(0, 0, 0), vec3(0, 0, 0), 0);
    send_item(MODE_SPHERE, vec3(0, 0, 0), vec3(0, 0, 0), 1);
    send_item(MODE_BOX, vec3(-1, -1, -1), vec3(1, 1, 1), 0);
    send_item(MODE_NONE, vec3(-1, -1, -1), vec3(-1, -1, -1), '1);
    drain();

    // Axis-aligned cube of half width W.
    plane_set[0] = make_plane(2048, 0, 0, -W);
    plane_set[1] = make_plane(-2048, 0, 0, -W);
    plane_set[2] = make_plane(0, -2048, 0, -W);
    plane_set[3] = make_plane(0, 2048, 0, -W);
    plane_set[4] = make_plane(0, 0, -2048, -W);
    plane_set[5] = make_plane(0, 0, 2048, -W);
    load_planes();
    send_item(MODE_POINT, vec3(0, 0, 0), vec3(0, 0, 0), 0);
    send_item(MODE_POINT, vec3(W, 0, 0), vec3(0, 0, 0), 0);
    send_item(MODE_POINT, vec3(W - 1, 0, 0), vec3(0, 0, 0), 0);
    send_item(MODE_POINT, vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(0, 0, 0), 0);
    send_item(MODE_POINT, vec3(COORD_MAX, COORD_MAX, COORD_MAX), vec3(0, 0, 0), 0);
    send_item(MODE_SPHERE, vec3(W + 100, 0, 0), vec3(0, 0, 0), 101);
    send_item(MODE_SPHERE, vec3(W + 100, 0, 0), vec3(0, 0, 0), 100);
    send_item(MODE_SPHERE, vec3(COORD_MAX, COORD_MAX, COORD_MAX), vec3(0, 0, 0), '1);
    send_item(MODE_SPHERE, vec3(0, 0, 0), vec3(0, 0, 0), 0);
    send_item(MODE_BOX, vec3(W - 10, W - 10, W - 10), vec3(W + 10, W + 10, W + 10), 0);
    send_item(MODE_BOX, vec3(W + 1, 0, 0), vec3(W + 5, 10, 10), 0);
    // Minimum above maximum: the entry stage sorts the corners.
    send_item(MODE_BOX, vec3(W + 5, 0, 0), vec3(W - 5, 10, 10), 0);
    send_item(MODE_BOX, vec3(W + 10, 0, 0), vec3(W + 1, 10, 10), 0);
    send_item(MODE_BOX, vec3(COORD_MIN, COORD_MIN, COORD_MIN),
              vec3(COORD_MAX, COORD_MAX, COORD_MAX), 0);
    send_item(MODE_BOX, vec3(COORD_MAX, COORD_MAX, COORD_MAX),
              vec3(COORD_MIN, COORD_MIN, COORD_MIN), 0);
    send_item(MODE_NONE, vec3(0, 0, 0), vec3(0, 0, 0), 0);
    for (i = 0; i < 300; i++) send_random(W + W / 2);
    drain();

    // Fully random planes.
    for (i = 0; i < NUM_PLANES; i++) plane_set[i] = {$urandom(), $urandom()};
    load_planes();
    for (i = 0; i < 200; i++) send_random(i[0] ? 0 : 4 * W);
    drain();

    // Field extremes in every part of the plane registers.
    plane_set[0] = '1;
    plane_set[1] = 64'h8000_0000_0000_0000;
    plane_set[2] = 64'h7FFF_FFFF_FFFF_FFFF;
    plane_set[3] = make_plane(-4096, 4095, 0, 16777215);
    plane_set[4] = make_plane(4095, 4095, 4095, -16777216);
    plane_set[5] = '0;
    load_planes();
    for (i = 0; i < 150; i++) send_random(i[0] ? 0 : W);
    drain();

    // Tilted planes around the origin.
    for (i = 0; i < NUM_PLANES; i++) begin
      plane_set[i] = make_plane(rand_coord(2048), rand_coord(2048), rand_coord(2048),
                                -int'($urandom_range(400000)));
    end
    load_planes();
    for (i = 0; i < 300; i++) send_random(W);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
